// ===== hw/rtl/tlbpfr_pkg.sv =====
`default_nettype none
package tlbpfr_pkg;

    localparam int FRAME_DEPTH_DEF = 16;
    localparam int TLB_DEPTH_DEF   = 8;
    localparam int PAGE_BITS_DEF   = 12;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_ALG    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WB     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TLB    = 2'd3;

    localparam logic [1:0] POL_FIFO  = 2'd0;
    localparam logic [1:0] POL_LRU   = 2'd1;
    localparam logic [1:0] POL_CLOCK = 2'd2;

    localparam logic [1:0] OUT_TLB_HIT   = 2'd0;
    localparam logic [1:0] OUT_FRAME_HIT = 2'd1;
    localparam logic [1:0] OUT_FAULT     = 2'd2;

    localparam logic [4:0] FRAMES_RESET = 5'd3;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_TSCAN = 8'b0000_0010,
        S_FSCAN = 8'b0000_0100,
        S_CLOCK = 8'b0000_1000,
        S_EVRD  = 8'b0001_0000,
        S_INST  = 8'b0010_0000,
        S_TPUT  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

endpackage
`default_nettype wire

// ===== hw/rtl/tlb_and_page_frame_replacement.sv =====
`default_nettype none
// TLB and page frame replacement unit.
// Input channel (i_in_valid/o_in_ready) takes one access beat: command
// (0 read, 1 write) and a byte address. Output channel (o_out_valid/
// i_out_ready) gives one result beat per access: outcome, frame, eviction
// details and dirty write-back flag. Configuration beats on i_cfg_* set the
// replacement policy, write-back mode, frame count and TLB size.
// One access is handled at a time. A TLB hit ends the TLB scan and goes on
// to load the result. A TLB miss goes through the TLB scan, the frame scan,
// a CLOCK sweep under the CLOCK policy, the victim read and install (not on
// a frame hit), the TLB update and the loading of the result; with tn TLB
// entries in use and tn = 0 the TLB scan and update are skipped. The scans
// read the page/stamp and TLB memories one entry per cycle.
// The result sits in an output register; a stalled receiver holds the unit
// in its final step until the beat is taken, and the next access is
// accepted as soon as the result is loaded.
// Reset clears all valid, reference and dirty bits, pointers, the access
// counter and the registers to their defaults; memories need no clearing.
module tlb_and_page_frame_replacement #(
    parameter int FRAME_DEPTH = tlbpfr_pkg::FRAME_DEPTH_DEF,
    parameter int TLB_DEPTH   = tlbpfr_pkg::TLB_DEPTH_DEF,
    parameter int PAGE_BITS   = tlbpfr_pkg::PAGE_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic                             i_command,
    input  wire logic [31:0]                      i_address,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic      [1:0]                       o_outcome,
    output logic      [3:0]                       o_frame,
    output logic                                  o_evicted,
    output logic      [19:0]                      o_evicted_page,
    output logic                                  o_dirty_writeback,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [tlbpfr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [tlbpfr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tlbpfr_pkg::*;

    localparam int FW  = FRAME_DEPTH > 1 ? $clog2(FRAME_DEPTH) : 1;
    localparam int CW  = $clog2(FRAME_DEPTH + 1);
    localparam int TW  = TLB_DEPTH > 1 ? $clog2(TLB_DEPTH) : 1;
    localparam int TCW = $clog2(TLB_DEPTH + 1);
    localparam int SW  = CW > TCW ? CW : TCW;
    localparam int PW  = 32 - PAGE_BITS;
    localparam int TWD = PW + FW + 32;

    // configuration
    logic [1:0] r_alg;
    logic       r_wb;
    logic [4:0] r_frames;
    logic [3:0] r_tlbn;

    // control state
    t_state r_state;
    logic [FRAME_DEPTH-1:0] r_fvalid, r_ref, r_dirty, r_sset;
    logic [TLB_DEPTH-1:0]   r_tvalid;
    logic [FW-1:0] r_fifo, r_hand, r_h, r_hstart, r_v;
    logic [31:0]   r_tick;
    logic [SW-1:0] r_sidx, r_pidx;
    logic          r_pend;
    logic [CW:0]   r_k;

    // per-access working registers
    logic          r_cmd;
    logic [PW-1:0] r_page, r_evpage;
    logic          r_ev, r_dwb;
    logic [1:0]    r_outcome;
    logic          r_emp_ok;
    logic [FW-1:0] r_emp, r_minidx;
    logic [31:0]   r_min;
    logic          r_temp_ok;
    logic [TW-1:0] r_temp, r_tminidx;
    logic [31:0]   r_tmin;

    // output register
    logic          r_out_valid;
    logic [1:0]    r_o_outcome;
    logic [3:0]    r_o_frame;
    logic          r_o_ev, r_o_dwb;
    logic [19:0]   r_o_evpage;

    // memories
    logic [PW-1:0]  w_page_rd, w_page_wd;
    logic [FW-1:0]  w_page_ra;
    logic           w_page_we;
    logic [31:0]    w_stamp_rd;
    logic           w_stamp_we;
    logic [TWD-1:0] w_tlb_rd, w_tlb_wd;
    logic [TW-1:0]  w_tlb_wa;
    logic           w_tlb_we;

    logic [CW-1:0]  w_n;
    logic [TCW-1:0] w_tn;
    logic [SW-1:0]  w_lim;
    logic           w_issue, w_sdone;
    logic [FW-1:0]  w_fp;
    logic [TW-1:0]  w_tp;
    logic [PW-1:0]  w_rd_tpage;
    logic [FW-1:0]  w_rd_tframe;
    logic [31:0]    w_rd_tstamp, w_fstamp;
    logic           w_thit, w_fhit, w_drop;
    logic           w_touch;
    logic [FW-1:0]  w_tf;
    logic [FW-1:0]  w_hand0, w_fifo0, w_hnext;
    logic [FW+3:0]  w_frame_ext;
    logic [PW+19:0] w_evp_ext;
    logic [TW-1:0]  w_tput_idx;

    always_comb begin
        if (r_frames == 5'd0) begin
            w_n = CW'(1);
        end else if ({4'b0, r_frames} > 9'(FRAME_DEPTH)) begin
            w_n = CW'(FRAME_DEPTH);
        end else begin
            w_n = CW'(r_frames);
        end
        if ({3'b0, r_tlbn} > 7'(TLB_DEPTH)) begin
            w_tn = TCW'(TLB_DEPTH);
        end else begin
            w_tn = TCW'(r_tlbn);
        end
    end

    assign w_lim   = (r_state == S_FSCAN) ? SW'(w_n) : SW'(w_tn);
    assign w_issue = r_sidx < w_lim;
    assign w_sdone = !r_pend && !w_issue;
    assign w_fp    = r_pidx[FW-1:0];
    assign w_tp    = r_pidx[TW-1:0];

    assign w_rd_tpage  = w_tlb_rd[TWD-1 -: PW];
    assign w_rd_tframe = w_tlb_rd[FW+31:32];
    assign w_rd_tstamp = w_tlb_rd[31:0];
    assign w_fstamp    = r_sset[w_fp] ? w_stamp_rd : 32'd0;

    assign w_thit = (r_state == S_TSCAN) && r_pend && r_tvalid[w_tp]
                    && (w_rd_tpage == r_page);
    assign w_fhit = (r_state == S_FSCAN) && r_pend && r_fvalid[w_fp]
                    && (w_page_rd == r_page);
    assign w_drop = (r_state == S_TPUT) && r_pend && r_ev && r_tvalid[w_tp]
                    && (w_rd_tpage == r_evpage);

    always_comb begin
        w_touch = 1'b0;
        w_tf    = r_v;
        if (w_thit) begin
            w_touch = CW'(w_rd_tframe) < w_n;
            w_tf    = w_rd_tframe;
        end else if (w_fhit) begin
            w_touch = 1'b1;
            w_tf    = w_fp;
        end else if (r_state == S_INST) begin
            w_touch = 1'b1;
        end
    end

    assign w_hand0 = (CW'(r_hand) < w_n) ? r_hand : '0;
    assign w_fifo0 = (CW'(r_fifo) < w_n) ? r_fifo : '0;
    assign w_hnext = (CW'(r_h) + CW'(1) == w_n) ? '0 : r_h + FW'(1);
    assign w_tput_idx = r_temp_ok ? r_temp : r_tminidx;

    assign w_page_we = (r_state == S_INST);
    assign w_page_wd = r_page;
    assign w_page_ra = (r_state == S_EVRD) ? r_v : r_sidx[FW-1:0];
    assign w_stamp_we = w_touch && (r_alg == POL_LRU);

    always_comb begin
        w_tlb_we = 1'b0;
        w_tlb_wa = w_tp;
        w_tlb_wd = {w_rd_tpage, w_rd_tframe, r_tick};
        if (w_thit) begin
            w_tlb_we = 1'b1;
        end else if (r_state == S_TPUT && w_sdone) begin
            w_tlb_we = 1'b1;
            w_tlb_wa = w_tput_idx;
            w_tlb_wd = {r_page, r_v, r_tick};
        end
    end

    tlbpfr_ram #(.WIDTH(PW), .DEPTH(FRAME_DEPTH)) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (w_page_we),
        .i_waddr (r_v),
        .i_wdata (w_page_wd),
        .i_raddr (w_page_ra),
        .o_rdata (w_page_rd)
    );

    tlbpfr_ram #(.WIDTH(32), .DEPTH(FRAME_DEPTH)) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (w_stamp_we),
        .i_waddr (w_tf),
        .i_wdata (r_tick),
        .i_raddr (r_sidx[FW-1:0]),
        .o_rdata (w_stamp_rd)
    );

    tlbpfr_ram #(.WIDTH(TWD), .DEPTH(TLB_DEPTH)) u_tlb_ram (
        .i_clk   (i_clk),
        .i_we    (w_tlb_we),
        .i_waddr (w_tlb_wa),
        .i_wdata (w_tlb_wd),
        .i_raddr (r_sidx[TW-1:0]),
        .o_rdata (w_tlb_rd)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_outcome   = r_o_outcome;
    assign o_frame     = r_o_frame;
    assign o_evicted   = r_o_ev;
    assign o_evicted_page    = r_o_evpage;
    assign o_dirty_writeback = r_o_dwb;

    assign w_frame_ext = {4'b0, r_v};
    assign w_evp_ext   = {20'b0, r_evpage};

    // payload-only registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_cmd  <= i_command;
            r_page <= i_address[31:PAGE_BITS];
        end
        if (r_state == S_DONE && (!r_out_valid || i_out_ready)) begin
            r_o_outcome <= r_outcome;
            r_o_frame   <= w_frame_ext[3:0];
            r_o_ev      <= r_ev;
            r_o_dwb     <= r_dwb;
            r_o_evpage  <= r_ev ? w_evp_ext[19:0] : 20'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alg       <= POL_FIFO;
            r_wb        <= 1'b0;
            r_frames    <= FRAMES_RESET;
            r_tlbn      <= 4'd0;
            r_state     <= S_IDLE;
            r_fvalid    <= '0;
            r_ref       <= '0;
            r_dirty     <= '0;
            r_sset      <= '0;
            r_tvalid    <= '0;
            r_fifo      <= '0;
            r_hand      <= '0;
            r_tick      <= '0;
            r_pend      <= 1'b0;
            r_sidx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_ALG:    r_alg    <= i_cfg_data[1:0];
                    CFG_WB:     r_wb     <= i_cfg_data[0];
                    CFG_FRAMES: r_frames <= i_cfg_data;
                    CFG_TLB:    r_tlbn   <= i_cfg_data[3:0];
                    default:    ;
                endcase
            end

            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            // scan pipeline: issue one read per cycle, compare in the cycle after
            if (r_state == S_TSCAN || r_state == S_FSCAN || r_state == S_TPUT) begin
                r_sidx <= r_sidx + SW'(w_issue);
                r_pend <= w_issue;
                r_pidx <= r_sidx;
            end

            if (w_drop) begin
                r_tvalid[w_tp] <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_tick    <= r_tick + 32'd1;
                        r_ev      <= 1'b0;
                        r_dwb     <= 1'b0;
                        r_sidx    <= '0;
                        r_pend    <= 1'b0;
                        r_emp_ok  <= 1'b0;
                        r_temp_ok <= 1'b0;
                        r_state   <= (w_tn != '0) ? S_TSCAN : S_FSCAN;
                    end
                end
                S_TSCAN: begin
                    if (w_thit) begin
                        r_v       <= w_rd_tframe;
                        r_outcome <= OUT_TLB_HIT;
                        r_state   <= S_DONE;
                    end else if (w_sdone) begin
                        r_sidx  <= '0;
                        r_pend  <= 1'b0;
                        r_state <= S_FSCAN;
                    end
                end
                S_FSCAN: begin
                    if (r_pend && !r_fvalid[w_fp] && !r_emp_ok) begin
                        r_emp_ok <= 1'b1;
                        r_emp    <= w_fp;
                    end
                    if (r_pend && (w_fp == '0 || w_fstamp < r_min)) begin
                        r_min    <= w_fstamp;
                        r_minidx <= w_fp;
                    end
                    if (w_fhit) begin
                        r_v       <= w_fp;
                        r_outcome <= OUT_FRAME_HIT;
                        r_sidx    <= '0;
                        r_pend    <= 1'b0;
                        r_state   <= (w_tn != '0) ? S_TPUT : S_DONE;
                    end else if (w_sdone) begin
                        r_outcome <= OUT_FAULT;
                        if (r_emp_ok) begin
                            r_v     <= r_emp;
                            r_state <= S_EVRD;
                        end else if (r_alg == POL_LRU) begin
                            r_v     <= r_minidx;
                            r_state <= S_EVRD;
                        end else if (r_alg == POL_CLOCK) begin
                            r_h      <= w_hand0;
                            r_hstart <= w_hand0;
                            r_k      <= '0;
                            r_state  <= S_CLOCK;
                        end else begin
                            r_v     <= w_fifo0;
                            r_fifo  <= ((CW'(w_fifo0) + CW'(1)) == w_n) ? '0
                                       : w_fifo0 + FW'(1);
                            r_state <= S_EVRD;
                        end
                    end
                end
                S_CLOCK: begin
                    // give a second chance: a set bit is cleared and the hand advances; a clear bit picks the victim
                    if (!r_ref[r_h]) begin
                        r_v     <= r_h;
                        r_hand  <= w_hnext;
                        r_state <= S_EVRD;
                    end else begin
                        r_ref[r_h] <= 1'b0;
                        r_h        <= w_hnext;
                        r_k        <= r_k + (CW+1)'(1);
                        if (r_k == {w_n, 1'b0}) begin
                            r_v     <= r_hstart;
                            r_hand  <= w_hnext;
                            r_state <= S_EVRD;
                        end
                    end
                end
                S_EVRD: begin
                    r_state <= S_INST;
                end
                S_INST: begin
                    if (r_fvalid[r_v]) begin
                        r_ev     <= 1'b1;
                        r_evpage <= w_page_rd;
                        if (r_wb && r_dirty[r_v]) begin
                            r_dwb          <= 1'b1;
                            r_dirty[r_v]   <= 1'b0;
                        end
                    end
                    r_fvalid[r_v] <= 1'b1;
                    r_sidx  <= '0;
                    r_pend  <= 1'b0;
                    r_state <= (w_tn != '0) ? S_TPUT : S_DONE;
                end
                S_TPUT: begin
                    if (r_pend && !(r_tvalid[w_tp] && !w_drop) && !r_temp_ok) begin
                        r_temp_ok <= 1'b1;
                        r_temp    <= w_tp;
                    end
                    if (r_pend && (w_tp == '0 || w_rd_tstamp < r_tmin)) begin
                        r_tmin    <= w_rd_tstamp;
                        r_tminidx <= w_tp;
                    end
                    if (w_sdone) begin
                        r_tvalid[w_tput_idx] <= 1'b1;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            // touch after any dirty clear so a write re-marks the frame
            if (w_touch) begin
                if (r_alg == POL_CLOCK) begin
                    r_ref[w_tf] <= 1'b1;
                end
                if (r_alg == POL_LRU) begin
                    r_sset[w_tf] <= 1'b1;
                end
                if (r_cmd && r_wb) begin
                    r_dirty[w_tf] <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/tlbpfr_ram.sv =====
`default_nettype none
module tlbpfr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire
